FILE: rtl/core/tei_pkg.sv
package tei_pkg;

    // Privilege levels
    localparam logic [1:0] PRIV_U = 2'd0;
    localparam logic [1:0] PRIV_S = 2'd1;
    localparam logic [1:0] PRIV_M = 2'd3;

    // mstatus bit positions
    localparam int ST_SIE  = 1;
    localparam int ST_MIE  = 3;
    localparam int ST_SPIE = 5;
    localparam int ST_MPIE = 7;
    localparam int ST_SPP  = 8;
    localparam int ST_MPP  = 11;

    // Item function codes
    localparam logic FUNC_EXC = 1'b0;
    localparam logic FUNC_IRQ = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_MEDELEG = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIDELEG = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MTVEC   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STVEC   = 8'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIE     = 8'd4;

    // Vector mode code that selects vectored interrupts
    localparam logic [1:0] VEC_MODE_VECTORED = 2'd1;

    // Interrupt priority: MEI, MSI, MTI, SEI, SSI, STI
    localparam int NUM_IRQ = 6;
    localparam logic [4:0] IRQ_ORDER [NUM_IRQ] = '{5'd11, 5'd3, 5'd7, 5'd9, 5'd1, 5'd5};

    typedef struct packed {
        logic [31:0] medeleg;
        logic [31:0] mideleg;
        logic [31:0] mtvec;
        logic [31:0] stvec;
        logic [31:0] mie;
    } t_cfg;

    typedef struct packed {
        logic        func;
        logic [31:0] cur_pc;
        logic [4:0]  exc_cause;
        logic [31:0] trap_value;
        logic [31:0] pending_bits;
    } t_item;

    typedef struct packed {
        logic        trap_taken;
        logic [31:0] next_pc;
        logic [1:0]  next_priv;
        logic        to_supervisor;
        logic [31:0] cause_word;
        logic        vector_zero;
        logic [31:0] status_word;
    } t_result;

    // Trap CSR writeback for the target mode
    typedef struct packed {
        logic        wr_m;
        logic        wr_s;
        logic [31:0] epc;
        logic [31:0] cause;
        logic [31:0] tval;
    } t_csr_wr;

endpackage

FILE: rtl/core/tei_entry.sv
module tei_entry (
    input  tei_pkg::t_cfg    i_cfg,
    input  tei_pkg::t_item   i_item,
    input  logic [1:0]       i_priv,
    input  logic [31:0]      i_status,
    output tei_pkg::t_result o_result,
    output tei_pkg::t_csr_wr o_csr_wr
);

    logic        live_any;
    logic [31:0] live;
    logic        irq_found;
    logic [4:0]  irq_code;
    logic        irq_ok;
    logic        deleg_irq;
    logic        taken;
    logic        intr;
    logic [4:0]  code;
    logic        deleg_bit;
    logic        to_s;
    logic [31:0] cause;
    logic [31:0] st;
    logic [31:0] vec;
    logic [31:0] target;

    // Select the highest-priority interrupt that is allowed to fire
    always_comb begin
        live      = i_item.pending_bits & i_cfg.mie;
        irq_found = 1'b0;
        irq_code  = 5'd0;
        live_any  = 1'b0;
        deleg_irq = 1'b0;
        irq_ok    = 1'b0;
        for (int i = 0; i < tei_pkg::NUM_IRQ; i++) begin
            live_any  = live[tei_pkg::IRQ_ORDER[i]];
            deleg_irq = i_cfg.mideleg[tei_pkg::IRQ_ORDER[i]];
            if (deleg_irq) begin
                if (i_priv == tei_pkg::PRIV_M) begin
                    irq_ok = 1'b0;
                end else if (i_priv == tei_pkg::PRIV_S) begin
                    irq_ok = i_status[tei_pkg::ST_SIE];
                end else begin
                    irq_ok = 1'b1;
                end
            end else begin
                irq_ok = (i_priv == tei_pkg::PRIV_M) ? i_status[tei_pkg::ST_MIE] : 1'b1;
            end
            if (!irq_found && live_any && irq_ok) begin
                irq_found = 1'b1;
                irq_code  = tei_pkg::IRQ_ORDER[i];
            end
        end
    end

    // Resolve target mode and build the new status
    always_comb begin
        intr      = (i_item.func == tei_pkg::FUNC_IRQ);
        taken     = intr ? irq_found : 1'b1;
        code      = intr ? irq_code : i_item.exc_cause;
        deleg_bit = intr ? i_cfg.mideleg[code] : i_cfg.medeleg[code];
        to_s      = (i_priv != tei_pkg::PRIV_M) && deleg_bit;
        cause     = {intr, 26'd0, code};
        st        = i_status;
        if (to_s) begin
            st[tei_pkg::ST_SPIE] = i_status[tei_pkg::ST_SIE];
            st[tei_pkg::ST_SIE]  = 1'b0;
            st[tei_pkg::ST_SPP]  = (i_priv == tei_pkg::PRIV_S);
            vec                  = i_cfg.stvec;
        end else begin
            st[tei_pkg::ST_MPIE] = i_status[tei_pkg::ST_MIE];
            st[tei_pkg::ST_MIE]  = 1'b0;
            st[tei_pkg::ST_MPP+1:tei_pkg::ST_MPP] = i_priv;
            vec                  = i_cfg.mtvec;
        end
        target = {vec[31:2], 2'b00};
        if (intr && vec[1:0] == tei_pkg::VEC_MODE_VECTORED) begin
            target = target + {25'd0, code, 2'b00};
        end
    end

    // Drive result and CSR writeback
    always_comb begin
        if (taken) begin
            o_result.trap_taken    = 1'b1;
            o_result.next_pc       = target;
            o_result.next_priv     = to_s ? tei_pkg::PRIV_S : tei_pkg::PRIV_M;
            o_result.to_supervisor = to_s;
            o_result.cause_word    = cause;
            o_result.vector_zero   = (target == 32'd0);
            o_result.status_word   = st;
        end else begin
            o_result.trap_taken    = 1'b0;
            o_result.next_pc       = i_item.cur_pc;
            o_result.next_priv     = i_priv;
            o_result.to_supervisor = 1'b0;
            o_result.cause_word    = 32'd0;
            o_result.vector_zero   = 1'b0;
            o_result.status_word   = i_status;
        end
        o_csr_wr.wr_m  = taken && !to_s;
        o_csr_wr.wr_s  = taken && to_s;
        o_csr_wr.epc   = i_item.cur_pc;
        o_csr_wr.cause = cause;
        o_csr_wr.tval  = intr ? 32'd0 : i_item.trap_value;
    end

endmodule

FILE: rtl/core/trap_entry_and_interrupt_select_top.sv
// Pipeline: input register, then result register.
// Throughput: one item per cycle unless the output stalls; the trap decision is one
// combinational pass into the result register; privilege/status update at that edge.
// Reset (synchronous, active low): privilege to machine mode, status, trap CSRs and
// configuration registers to zero, both pipeline registers empty.
module trap_entry_and_interrupt_select_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // item input
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_func,
    input  logic [31:0] i_cur_pc,
    input  logic [4:0]  i_exc_cause,
    input  logic [31:0] i_trap_value,
    input  logic [31:0] i_pending_bits,
    // result output
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_trap_taken,
    output logic [31:0] o_next_pc,
    output logic [1:0]  o_next_priv,
    output logic        o_to_supervisor,
    output logic [31:0] o_cause_word,
    output logic        o_vector_zero,
    output logic [31:0] o_status_word,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [tei_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    tei_pkg::t_cfg    r_cfg;
    tei_pkg::t_item   r_item;
    logic             r_in_valid;
    tei_pkg::t_result r_result;
    logic             r_out_valid;
    logic [1:0]       r_priv;
    logic [31:0]      r_status;
    logic [31:0]      r_mepc;
    logic [31:0]      r_mcause;
    logic [31:0]      r_mtval;
    logic [31:0]      r_sepc;
    logic [31:0]      r_scause;
    logic [31:0]      r_stval;

    tei_pkg::t_result n_result;
    tei_pkg::t_csr_wr csr_wr;
    logic             advance;

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    tei_entry u_entry (
        .i_cfg    (r_cfg),
        .i_item   (r_item),
        .i_priv   (r_priv),
        .i_status (r_status),
        .o_result (n_result),
        .o_csr_wr (csr_wr)
    );

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tei_pkg::CFG_MEDELEG: r_cfg.medeleg <= i_cfg_data;
                tei_pkg::CFG_MIDELEG: r_cfg.mideleg <= i_cfg_data;
                tei_pkg::CFG_MTVEC:   r_cfg.mtvec   <= i_cfg_data;
                tei_pkg::CFG_STVEC:   r_cfg.stvec   <= i_cfg_data;
                tei_pkg::CFG_MIE:     r_cfg.mie     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Capture the input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_item.func         <= i_func;
            r_item.cur_pc       <= i_cur_pc;
            r_item.exc_cause    <= i_exc_cause;
            r_item.trap_value   <= i_trap_value;
            r_item.pending_bits <= i_pending_bits;
        end
    end

    // Advance into the result register and commit hart state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_priv      <= tei_pkg::PRIV_M;
            r_status    <= '0;
            r_mepc      <= '0;
            r_mcause    <= '0;
            r_mtval     <= '0;
            r_sepc      <= '0;
            r_scause    <= '0;
            r_stval     <= '0;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                r_priv      <= n_result.next_priv;
                r_status    <= n_result.status_word;
                if (csr_wr.wr_m) begin
                    r_mepc   <= csr_wr.epc;
                    r_mcause <= csr_wr.cause;
                    r_mtval  <= csr_wr.tval;
                end
                if (csr_wr.wr_s) begin
                    r_sepc   <= csr_wr.epc;
                    r_scause <= csr_wr.cause;
                    r_stval  <= csr_wr.tval;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_trap_taken    = r_result.trap_taken;
    assign o_next_pc       = r_result.next_pc;
    assign o_next_priv     = r_result.next_priv;
    assign o_to_supervisor = r_result.to_supervisor;
    assign o_cause_word    = r_result.cause_word;
    assign o_vector_zero   = r_result.vector_zero;
    assign o_status_word   = r_result.status_word;

endmodule
